@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define GBN_ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("greedy_box_nms: invariant violated");
// Consequent must hold in the same cycle as the antecedent.
`define GBN_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("greedy_box_nms: implication violated");
// Consequent must hold in the cycle after the antecedent.
`define GBN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("greedy_box_nms: next-cycle implication violated");
`else
`define GBN_ASSERT_ALWAYS(lbl, clk, rst, prop)
`define GBN_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define GBN_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/gbn_pkg.sv @@
// Shared constants and types of the greedy box suppression block.
package gbn_pkg;

   localparam int MaxKept   = 64;
   localparam int MaxBoxes  = 4096;

   localparam int CoordW    = 16;
   localparam int SizeW     = 15;
   localparam int AreaW     = 2 * SizeW;
   localparam int UnionW    = AreaW + 1;
   localparam int ThrW      = 16;
   localparam int ProdW     = ThrW + UnionW;
   localparam int IndexW    = 12;

   localparam int IdxW      = (MaxKept > 1) ? $clog2(MaxKept) : 1;
   localparam int CountW    = $clog2(MaxKept + 1);
   localparam int BoxCountW = $clog2(MaxBoxes);

   localparam logic [ThrW-1:0] ThrResetValue = 16'd39322;

   // One box as held in the kept list.
   typedef struct packed {
      logic signed [CoordW-1:0] left;
      logic signed [CoordW-1:0] top;
      logic [SizeW-1:0]         width;
      logic [SizeW-1:0]         height;
      logic [AreaW-1:0]         area;
   } entry_type;

   // Status of the overlap unit toward the sequencer.
   typedef struct packed {
      logic busy;
      logic hit;
   } iou_status_type;

endpackage

@@ rtl/gbn_channels.sv @@
// Request and response channel interfaces of the greedy box suppression block.
interface gbn_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [gbn_pkg::CoordW-1:0]    box_left;
   logic signed [gbn_pkg::CoordW-1:0]    box_top;
   logic [gbn_pkg::SizeW-1:0]            box_width;
   logic [gbn_pkg::SizeW-1:0]            box_height;
   logic                                 last_box;

   modport source (output valid, box_left, box_top, box_width, box_height, last_box,
                   input ready);
   modport sink (input valid, box_left, box_top, box_width, box_height, last_box,
                 output ready);
endinterface

interface gbn_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [gbn_pkg::IndexW-1:0]   box_index;
   logic                         keep;
   logic                         store_full;
   logic                         last_result;

   modport source (output valid, box_index, keep, store_full, last_result, input ready);
   modport sink (input valid, box_index, keep, store_full, last_result, output ready);
endinterface

@@ rtl/gbn_store.sv @@
// Kept-box list memory: one write port and one registered read port.
module gbn_store (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [gbn_pkg::IdxW-1:0] wr_addr,
   input  gbn_pkg::entry_type       wr_data,
   input  logic [gbn_pkg::IdxW-1:0] rd_addr,
   output gbn_pkg::entry_type       rd_data
);

   gbn_pkg::entry_type mem [gbn_pkg::MaxKept];
   gbn_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/gbn_iou.sv @@
// Pipelined overlap test of the candidate box against one kept box per cycle.
module gbn_iou (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  gbn_pkg::entry_type          kept,
   input  gbn_pkg::entry_type          cand,
   input  logic [gbn_pkg::ThrW-1:0]    thr,
   output gbn_pkg::iou_status_type     status
);

   // Overlap of [a0, a0+al) and [b0, b0+bl), zero when not positive.
   function automatic logic [gbn_pkg::SizeW-1:0] overlap(
      input logic signed [gbn_pkg::CoordW-1:0] a0,
      input logic [gbn_pkg::SizeW-1:0]         al,
      input logic signed [gbn_pkg::CoordW-1:0] b0,
      input logic [gbn_pkg::SizeW-1:0]         bl
   );
      logic signed [gbn_pkg::CoordW:0]   a_end;
      logic signed [gbn_pkg::CoordW:0]   b_end;
      logic signed [gbn_pkg::CoordW:0]   hi;
      logic signed [gbn_pkg::CoordW-1:0] lo;
      logic signed [gbn_pkg::CoordW+1:0] diff;
      a_end = $signed({a0[gbn_pkg::CoordW-1], a0}) + $signed({2'b00, al});
      b_end = $signed({b0[gbn_pkg::CoordW-1], b0}) + $signed({2'b00, bl});
      hi    = (a_end < b_end) ? a_end : b_end;
      lo    = (a0 > b0) ? a0 : b0;
      diff  = $signed({hi[gbn_pkg::CoordW], hi}) - $signed({{2{lo[gbn_pkg::CoordW-1]}}, lo});
      return (diff > 0) ? diff[gbn_pkg::SizeW-1:0] : '0;
   endfunction

   // Stage 1: side lengths of the intersection.
   logic                          s1_valid_ff;
   logic [gbn_pkg::SizeW-1:0]     s1_iw_ff, s1_ih_ff;
   logic [gbn_pkg::AreaW-1:0]     s1_karea_ff;
   // Stage 2: intersection area.
   logic                          s2_valid_ff;
   logic [gbn_pkg::AreaW-1:0]     s2_inter_ff, s2_karea_ff;
   // Stage 3: union area.
   logic                          s3_valid_ff;
   logic [gbn_pkg::AreaW-1:0]     s3_inter_ff;
   logic [gbn_pkg::UnionW-1:0]    s3_uni_ff;
   // Stage 4: threshold times union.
   logic                          s4_valid_ff;
   logic [gbn_pkg::AreaW-1:0]     s4_inter_ff;
   logic [gbn_pkg::ProdW-1:0]     s4_prod_ff;

   logic [gbn_pkg::ProdW-1:0]     scaled_inter;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_iw_ff    <= overlap(cand.left, cand.width, kept.left, kept.width);
      s1_ih_ff    <= overlap(cand.top, cand.height, kept.top, kept.height);
      s1_karea_ff <= kept.area;

      s2_inter_ff <= gbn_pkg::AreaW'(s1_iw_ff) * gbn_pkg::AreaW'(s1_ih_ff);
      s2_karea_ff <= s1_karea_ff;

      s3_inter_ff <= s2_inter_ff;
      s3_uni_ff   <= gbn_pkg::UnionW'(cand.area) + gbn_pkg::UnionW'(s2_karea_ff)
                     - gbn_pkg::UnionW'(s2_inter_ff);

      s4_inter_ff <= s3_inter_ff;
      s4_prod_ff  <= gbn_pkg::ProdW'(thr) * gbn_pkg::ProdW'(s3_uni_ff);
   end

   // The intersection scaled by 2^16 against threshold times union.
   assign scaled_inter = {1'b0, s4_inter_ff, 16'h0000};

   assign status.busy = s1_valid_ff | s2_valid_ff | s3_valid_ff | s4_valid_ff;
   assign status.hit  = s4_valid_ff && (scaled_inter > s4_prod_ff);

endmodule

@@ rtl/greedy_box_nms_unit.sv @@
// Top level of the greedy box non-maximum suppression block.
// With boxes in the kept list, each box beat is followed by one list read per cycle into four test
// stages; the result beat is loaded when the scan ends, and with an empty list the scan makes no read.
// Boxes do not overlap: a new box beat is taken only after the last box has left its scan.
// The next box beat is taken while a result beat waits; that box then holds in its last step.
// Reset (synchronous): empty kept list, box position zero, threshold 0.6 in Q0.16.
`include "assert_macros.svh"

module greedy_box_nms_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [gbn_pkg::ThrW-1:0]   csr_wdata,
   gbn_req_if.sink                    req_bus,
   gbn_rsp_if.source                  rsp_bus
);

   // Sequencer: IDLE takes a box beat, SCAN streams the kept list through the
   // overlap unit, DONE writes the result beat and appends a surviving box if the list has room.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [gbn_pkg::ThrW-1:0]           thr_ff;
   gbn_pkg::entry_type                 cand_ff;
   logic                               cand_last_ff;
   logic [gbn_pkg::CountW-1:0]         kept_count_ff, kept_count_in;
   logic [gbn_pkg::BoxCountW-1:0]      box_count_ff, box_count_in;
   logic [gbn_pkg::CountW-1:0]         issue_ff, issue_in;
   logic                               rd_valid_ff, rd_valid_in;
   logic                               suppress_ff, suppress_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [gbn_pkg::IndexW-1:0]         rsp_index_ff;
   logic                               rsp_keep_ff, rsp_full_ff, rsp_last_ff;

   logic                               req_fire;
   logic                               out_free;
   logic                               done_fire;
   logic                               scan_done;
   logic                               keep_box;
   logic                               list_full;
   logic                               store_wr;
   gbn_pkg::entry_type                 kept_entry;
   gbn_pkg::iou_status_type            iou_stat;

   // The block takes a new box only between scans.
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // The result register is free when empty or drained this cycle.
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign done_fire = (state_ff == ST_DONE) && out_free;

   // The scan is over when every kept box has been read and the test pipeline
   // is empty, so the suppress flag already holds every comparison.
   assign scan_done = (issue_ff == kept_count_ff) && !rd_valid_ff && !iou_stat.busy;

   assign keep_box  = !suppress_ff;
   assign list_full = (kept_count_ff == gbn_pkg::CountW'(gbn_pkg::MaxKept));
   assign store_wr  = done_fire && keep_box && !list_full;

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= gbn_pkg::ThrResetValue;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   // Candidate box, held for the whole scan; its area is formed on capture.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cand_ff.left   <= req_bus.box_left;
         cand_ff.top    <= req_bus.box_top;
         cand_ff.width  <= req_bus.box_width;
         cand_ff.height <= req_bus.box_height;
         cand_ff.area   <= gbn_pkg::AreaW'(req_bus.box_width)
                           * gbn_pkg::AreaW'(req_bus.box_height);
         cand_last_ff   <= req_bus.last_box;
      end
   end

   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      rd_valid_in   = 1'b0;
      suppress_in   = suppress_ff | iou_stat.hit;
      kept_count_in = kept_count_ff;
      box_count_in  = box_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in    = ST_SCAN;
               issue_in    = '0;
               suppress_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (issue_ff != kept_count_ff) begin
               // One kept-box read per cycle.
               issue_in    = issue_ff + gbn_pkg::CountW'(1);
               rd_valid_in = 1'b1;
            end else if (scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (cand_last_ff) begin
                  // End of frame: the list and the box position start over.
                  kept_count_in = '0;
                  box_count_in  = '0;
               end else begin
                  if (store_wr) begin
                     kept_count_in = kept_count_ff + gbn_pkg::CountW'(1);
                  end
                  if (box_count_ff == gbn_pkg::BoxCountW'(gbn_pkg::MaxBoxes - 1)) begin
                     box_count_in = '0;
                  end else begin
                     box_count_in = box_count_ff + gbn_pkg::BoxCountW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         suppress_ff   <= 1'b0;
         kept_count_ff <= '0;
         box_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         rd_valid_ff   <= rd_valid_in;
         suppress_ff   <= suppress_in;
         kept_count_ff <= kept_count_in;
         box_count_ff  <= box_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result beat payload, loaded as the box finishes.
   always_ff @(posedge clock) begin
      if (done_fire) begin
         rsp_index_ff <= gbn_pkg::IndexW'(box_count_ff);
         rsp_keep_ff  <= keep_box;
         rsp_full_ff  <= keep_box && list_full;
         rsp_last_ff  <= cand_last_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.box_index   = rsp_index_ff;
   assign rsp_bus.keep        = rsp_keep_ff;
   assign rsp_bus.store_full  = rsp_full_ff;
   assign rsp_bus.last_result = rsp_last_ff;

   // Kept list; a surviving box goes into the first free slot.
   gbn_store u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (kept_count_ff[gbn_pkg::IdxW-1:0]),
      .wr_data (cand_ff),
      .rd_addr (issue_ff[gbn_pkg::IdxW-1:0]),
      .rd_data (kept_entry)
   );

   // Shared overlap test, one kept box per cycle.
   gbn_iou u_iou (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_valid_ff),
      .kept     (kept_entry),
      .cand     (cand_ff),
      .thr      (thr_ff),
      .status   (iou_stat)
   );

   `GBN_ASSERT_ALWAYS(a_count_bound, clock, reset, kept_count_ff <= gbn_pkg::CountW'(gbn_pkg::MaxKept))
   `GBN_ASSERT_IMPLY(a_full_implies_keep, clock, reset, rsp_valid_ff && rsp_full_ff, rsp_keep_ff)
   `GBN_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_bus.ready)
   `GBN_ASSERT_IMPLY(a_hit_in_scan, clock, reset, iou_stat.hit, state_ff == ST_SCAN)

endmodule
